@@ rtl/mcv_pkg.sv @@
// ----------------------------------------------------------------------------
// mcv_pkg - shared types and constants for the matrix coefficient of variation
// Beat payload structs, fixed field widths, default sizing and the derived
// widths used as defaults by the arithmetic units.
// ----------------------------------------------------------------------------
package mcv_pkg;

    // Default sizing
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_VALUE_BITS  = 20;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed field widths of the beats
    localparam int ENTRY_W  = 20;
    localparam int RESULT_W = 29;

    // Percent scale and the bits it adds to a product
    localparam int PCT_SCALE = 100;
    localparam int PCT_W     = 7;

    // Square-sum accumulator never grows past this width (saturates there)
    localparam int SS_MAX_W = 128;

    localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

    // Derived defaults for the arithmetic units
    localparam int DEF_CNT_W   = $clog2(DEF_MAX_ENTRIES + 1);
    localparam int DEF_MEAN_W  = DEF_VALUE_BITS + DEF_FRAC_BITS;
    localparam int DEF_SS_FULL = 2 * DEF_MEAN_W + DEF_CNT_W;
    localparam int DEF_SS_W    = (DEF_SS_FULL > SS_MAX_W) ? SS_MAX_W : DEF_SS_FULL;
    localparam int DEF_ROOT_W  = (DEF_SS_W + 1) / 2;
    localparam int DEF_D1      = DEF_VALUE_BITS + DEF_CNT_W + DEF_FRAC_BITS;
    localparam int DEF_D2      = (DEF_D1 > DEF_SS_W) ? DEF_D1 : DEF_SS_W;
    localparam int DEF_D3      = DEF_ROOT_W + PCT_W + DEF_FRAC_BITS;
    localparam int DEF_DVD_W   = (DEF_D2 > DEF_D3) ? DEF_D2 : DEF_D3;
    localparam int DEF_DVS_W   = (DEF_MEAN_W > DEF_CNT_W) ? DEF_MEAN_W : DEF_CNT_W;

    // Input beat: one matrix entry
    typedef struct packed {
        logic [ENTRY_W-1:0] entry_value;
        logic               last_entry;
    } t_in_beat;

    // Output beat: one result per matrix
    typedef struct packed {
        logic [RESULT_W-1:0] variation_percent;
        logic                mean_zero;
        logic                overflow_seen;
    } t_out_beat;

endpackage

@@ rtl/mcv_stream_if.sv @@
// ----------------------------------------------------------------------------
// mcv_stream_if - valid/ready stream channel
// Carries one payload beat per cycle; a beat moves when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface mcv_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mcv_divider.sv @@
// ----------------------------------------------------------------------------
// mcv_divider - iterative unsigned restoring divider
// One quotient bit per cycle. Operands are captured on i_start; o_done
// pulses when the quotient is final and it holds until the next start.
// ----------------------------------------------------------------------------
module mcv_divider
    import mcv_pkg::*;
#(
    parameter int DVD_W = DEF_DVD_W,
    parameter int DVS_W = DEF_DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_div;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // Shift in the next dividend bit, trial subtract
    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    // Iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/mcv_isqrt.sv @@
// ----------------------------------------------------------------------------
// mcv_isqrt - iterative integer square root
// Digit-by-digit method, one root bit per cycle (two radicand bits).
// Gives floor(sqrt(radicand)); o_done pulses when the root is final.
// ----------------------------------------------------------------------------
module mcv_isqrt
    import mcv_pkg::*;
#(
    parameter int ROOT_W = DEF_ROOT_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*ROOT_W-1:0] i_radicand,
    output logic                o_done,
    output logic [ROOT_W-1:0]   o_root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int RM_W  = ROOT_W + 2;
    localparam int CW    = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [RM_W-1:0]   r_rem;

    logic [RM_W+1:0]   w_shift;
    logic [RM_W+1:0]   w_trial;
    logic [RM_W+1:0]   w_diff;
    logic              w_ge;

    // Bring down two radicand bits, trial subtract 4*root+1
    assign w_shift = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = (RM_W + 2)'({r_root, 2'b01});
    assign w_diff  = w_shift - w_trial;
    assign w_ge    = (w_shift >= w_trial);

    // Iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOT_W - 1);
                r_rad  <= i_radicand;
                r_root <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[RM_W-1:0] : w_shift[RM_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/mcv_sqdev.sv @@
// ----------------------------------------------------------------------------
// mcv_sqdev - squared-deviation accumulate pipeline
// Takes one stored entry per cycle, forms |x * 2^F - mean|, squares it from
// three half-width partial products and adds the square into a saturating
// accumulator. Four register stages; o_busy is high while any beat is inside.
// ----------------------------------------------------------------------------
module mcv_sqdev
    import mcv_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int SS_W       = DEF_SS_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_valid,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  logic [VALUE_BITS+FRAC_BITS-1:0] i_mean,
    output logic                           o_busy,
    output logic [SS_W-1:0]                o_sum,
    output logic                           o_sat
);

    localparam int MW = VALUE_BITS + FRAC_BITS;
    localparam int H  = (MW + 1) / 2;
    localparam int LW = MW - H;

    logic              r_v1, r_v2, r_v3;
    logic [MW-1:0]     r_dev;
    logic [2*LW-1:0]   r_aa;
    logic [LW+H-1:0]   r_ab;
    logic [2*H-1:0]    r_bb;
    logic [2*MW-1:0]   r_sq;
    logic [SS_W-1:0]   r_acc;
    logic              r_sat;

    logic [MW-1:0]     w_xs;
    logic [LW-1:0]     w_hi;
    logic [H-1:0]      w_lo;
    logic [SS_W:0]     w_acc;

    assign w_xs  = {i_value, {FRAC_BITS{1'b0}}};
    assign w_hi  = r_dev[MW-1:H];
    assign w_lo  = r_dev[H-1:0];
    assign w_acc = {1'b0, r_acc} + (SS_W + 1)'(r_sq);

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Deviation, partial products, recombined square
    always_ff @(posedge i_clk) begin
        r_dev <= (w_xs >= i_mean) ? (w_xs - i_mean) : (i_mean - w_xs);
        r_aa  <= (2 * LW)'(w_hi) * (2 * LW)'(w_hi);
        r_ab  <= (LW + H)'(w_hi) * (LW + H)'(w_lo);
        r_bb  <= (2 * H)'(w_lo) * (2 * H)'(w_lo);
        r_sq  <= {r_aa, r_bb} + ((2 * MW)'(r_ab) << (H + 1));
    end

    // Saturating accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (r_v3) begin
            if (w_acc[SS_W]) begin
                r_acc <= '1;
                r_sat <= 1'b1;
            end else begin
                r_acc <= w_acc[SS_W-1:0];
            end
        end
    end

    assign o_busy = r_v1 | r_v2 | r_v3;
    assign o_sum  = r_acc;
    assign o_sat  = r_sat;

endmodule

@@ rtl/matrix_coefficient_of_variation_top.sv @@
// ----------------------------------------------------------------------------
// matrix_coefficient_of_variation_top - population coefficient of variation
// Takes the entries of a matrix, one per input beat (last_entry marks the
// final one), stores them and reports 100 * stddev / mean in fixed point.
// ----------------------------------------------------------------------------
// Entries stream in at one beat per cycle while the block is in its load
// state and are written into an on-chip entry store while a running sum is
// kept; entries beyond MAX_ENTRIES are dropped and flagged. After the last
// entry the block stops taking input and works through the matrix: a mean
// division, a second pass reading the store back at one entry per cycle
// (then a pipeline drain), a variance division, a square root and a final
// division. All three divisions share one iterative divider, DVD_W = 85
// bits wide at the default sizing, where ROOT_W = 43. A zero mean skips the
// pass and reports mean_zero with a zero result. The result beat sits in an
// output register; input is taken again as soon as it is loaded there. The
// entry store needs no clearing: only entries written for the current
// matrix are read.
// ----------------------------------------------------------------------------
module matrix_coefficient_of_variation_top
    import mcv_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mcv_stream_if.sink          i_in,
    mcv_stream_if.source        o_out
);

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int MEAN_W  = VALUE_BITS + FRAC_BITS;
    localparam int SUM_W   = VALUE_BITS + CNT_W;
    localparam int SS_FULL = 2 * MEAN_W + CNT_W;
    localparam int SS_W    = (SS_FULL > SS_MAX_W) ? SS_MAX_W : SS_FULL;
    localparam int ROOT_W  = (SS_W + 1) / 2;
    localparam int NUM_W   = ROOT_W + PCT_W;
    localparam int D1      = SUM_W + FRAC_BITS;
    localparam int D2      = (D1 > SS_W) ? D1 : SS_W;
    localparam int DVD_W   = (D2 > NUM_W + FRAC_BITS) ? D2 : (NUM_W + FRAC_BITS);
    localparam int DVS_W   = (MEAN_W > CNT_W) ? MEAN_W : CNT_W;
    localparam int XW      = (VALUE_BITS > ENTRY_W) ? VALUE_BITS : ENTRY_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MEAN,
        S_PASS,
        S_DRAIN,
        S_VAR,
        S_ROOT,
        S_RES,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_rd_addr;
    logic                  r_rd_valid;
    logic [VALUE_BITS-1:0] r_rd_data;
    logic [MEAN_W-1:0]     r_mean;
    logic [SS_W-1:0]       r_var;
    logic [ROOT_W-1:0]     r_std;
    logic [RESULT_W-1:0]   r_res;
    logic                  r_zero;
    logic                  r_sat_res;
    logic                  r_div_start;
    logic                  r_sqrt_start;
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic [VALUE_BITS-1:0] r_store [MAX_ENTRIES];

    logic [XW-1:0]         w_x_ext;
    logic [VALUE_BITS-1:0] w_x;
    logic                  w_in_fire;
    logic                  w_full;
    logic                  w_rd_en;
    logic [CNT_W-1:0]      n_count;
    logic [SUM_W-1:0]      n_sum;
    logic [NUM_W-1:0]      w_std_x100;
    logic [DVD_W-1:0]      w_dividend;
    logic [DVS_W-1:0]      w_divisor;
    logic                  w_div_done;
    logic [DVD_W-1:0]      w_quotient;
    logic                  w_sqrt_done;
    logic [ROOT_W-1:0]     w_root;
    logic                  w_sq_busy;
    logic [SS_W-1:0]       w_ss;
    logic                  w_ss_sat;

    // Input beat: keep only the low VALUE_BITS of the entry
    assign w_x_ext   = XW'(i_in.data.entry_value);
    assign w_x       = w_x_ext[VALUE_BITS-1:0];
    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_fire = i_in.valid & i_in.ready;
    assign w_full    = (r_count == CNT_W'(MAX_ENTRIES));
    assign n_count   = r_count + CNT_W'(1);
    assign n_sum     = r_sum + SUM_W'(w_x);
    assign w_rd_en   = (r_state == S_PASS);

    // Entry store: written during load, read back during the deviation pass
    always_ff @(posedge i_clk) begin
        if (w_in_fire && !w_full) begin
            r_store[r_count[AW-1:0]] <= w_x;
        end
        if (w_rd_en) begin
            r_rd_data <= r_store[r_rd_addr[AW-1:0]];
        end
    end

    // Divider operand select
    assign w_std_x100 = NUM_W'(r_std) * NUM_W'(PCT_SCALE);

    always_comb begin
        case (r_state)
            S_MEAN: begin
                w_dividend = DVD_W'(r_sum) << FRAC_BITS;
                w_divisor  = DVS_W'(r_count);
            end
            S_VAR: begin
                w_dividend = DVD_W'(w_ss);
                w_divisor  = DVS_W'(r_count);
            end
            default: begin
                w_dividend = DVD_W'(w_std_x100) << FRAC_BITS;
                w_divisor  = DVS_W'(r_mean);
            end
        endcase
    end

    mcv_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    mcv_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand ((2 * ROOT_W)'(r_var)),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    mcv_sqdev #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SS_W       (SS_W)
    ) u_sqdev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_state == S_MEAN),
        .i_valid (r_rd_valid),
        .i_value (r_rd_data),
        .i_mean  (r_mean),
        .o_busy  (w_sq_busy),
        .o_sum   (w_ss),
        .o_sat   (w_ss_sat)
    );

    // Sequencer: load, mean, pass, drain, variance, root, result, hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_sum        <= '0;
            r_ovf        <= 1'b0;
            r_rd_addr    <= '0;
            r_rd_valid   <= 1'b0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_rd_valid   <= w_rd_en;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_fire) begin
                        if (!w_full) begin
                            r_count <= n_count;
                            r_sum   <= n_sum;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.data.last_entry) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    if (w_div_done) begin
                        r_mean <= w_quotient[MEAN_W-1:0];
                        if (w_quotient[MEAN_W-1:0] == '0) begin
                            r_zero    <= 1'b1;
                            r_res     <= '0;
                            r_sat_res <= 1'b0;
                            r_state   <= S_DONE;
                        end else begin
                            r_zero    <= 1'b0;
                            r_rd_addr <= '0;
                            r_state   <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    r_rd_addr <= r_rd_addr + CNT_W'(1);
                    if (r_rd_addr == r_count - CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_valid && !w_sq_busy) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (w_div_done) begin
                        r_var        <= w_quotient[SS_W-1:0];
                        r_sqrt_start <= 1'b1;
                        r_state      <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_sqrt_done) begin
                        r_std       <= w_root;
                        r_div_start <= 1'b1;
                        r_state     <= S_RES;
                    end
                end
                S_RES: begin
                    if (w_div_done) begin
                        if (|w_quotient[DVD_W-1:RESULT_W]) begin
                            r_res     <= RESULT_MAX;
                            r_sat_res <= 1'b1;
                        end else begin
                            r_res     <= w_quotient[RESULT_W-1:0];
                            r_sat_res <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid             <= 1'b1;
                        r_out.variation_percent <= r_res;
                        r_out.mean_zero         <= r_zero;
                        r_out.overflow_seen     <= r_ovf | r_sat_res | (w_ss_sat & ~r_zero);
                        r_count                 <= '0;
                        r_sum                   <= '0;
                        r_ovf                   <= 1'b0;
                        r_state                 <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count past store depth");

    a_pass_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> (r_rd_addr < r_count))
        else $error("deviation pass reads past the kept entries");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside hand-off");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.mean_zero) |-> (o_out.data.variation_percent == '0))
        else $error("zero mean with nonzero result");

endmodule

@@ tb/sv/matrix_coefficient_of_variation_top_tb.sv @@
// ----------------------------------------------------------------------------
// matrix_coefficient_of_variation_top_tb - self-checking bench for the CV block
// Streams matrices into the block and checks every result beat against an
// in-bench fixed-point model of the population coefficient of variation.
// The directed tests cover field extremes, zero mean, widest spread and a
// full entry store. They are followed by random matrices, with random sender
// bursts and receiver stalls and a long output hold that backs up the block.
// ----------------------------------------------------------------------------
module matrix_coefficient_of_variation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcv_pkg::*;

    // Sizing matches the default instance
    localparam int STORE_DEPTH = DEF_MAX_ENTRIES;
    localparam int VALUE_W     = DEF_VALUE_BITS;
    localparam int FRAC_W      = DEF_FRAC_BITS;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;

    localparam int unsigned RANDOM_ITEMS     = 1600;
    localparam int unsigned LONG_HOLD_CYCLES = 3000;
    localparam int unsigned DRAIN_CYCLES     = 400;
    // Watchdog limit; kept well above the slowest correct run
    localparam int unsigned LIMIT_CYCLES     = 1000000;

    typedef enum {
        MIX_FULL_RANGE,
        MIX_SMALL,
        MIX_CONSTANT,
        MIX_ZERO,
        MIX_EXTREMES
    } matrix_mix_e;

    typedef enum {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC
    } sink_pacing_e;

    logic i_clk;
    logic i_rst_n;

    mcv_stream_if #(.t_payload(t_in_beat))  entry_if ();
    mcv_stream_if #(.t_payload(t_out_beat)) cv_if ();

    matrix_coefficient_of_variation_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (entry_if),
        .o_out   (cv_if)
    );

    // Model state for the matrix being loaded
    logic [VALUE_W-1:0] matrix_entries[$];
    logic [63:0]        matrix_sum;
    logic               matrix_dropped;
    t_out_beat          expected_cv[$];

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned burst_left;
    bit          sender_steady;
    bit          long_hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Fold one accepted entry into the model; on the last entry, predict the CV
    task automatic fold_entry(input logic [ENTRY_W-1:0] value, input logic last);
        logic [127:0]       mean_fx, dev, sq_sum, var_fx, root, trial, quo;
        logic [128:0]       acc;
        logic [VALUE_W-1:0] kept;
        logic               sat;
        int unsigned        n;
        t_out_beat          cv;
        kept = value[VALUE_W-1:0];
        // Entries past the store depth are dropped, not summed
        if (matrix_entries.size() < STORE_DEPTH) begin
            matrix_entries.push_back(kept);
            matrix_sum += 64'(kept);
        end else begin
            matrix_dropped = 1'b1;
        end
        if (last) begin
            n   = matrix_entries.size();
            sat = 1'b0;
            cv  = '0;
            mean_fx = (128'(matrix_sum) << FRAC_W) / 128'(n);
            if (mean_fx[127:64] != '0)
                mean_fx = 128'({64{1'b1}});
            if (mean_fx == '0) begin
                cv.mean_zero = 1'b1;
            end else begin
                // Second pass: saturating sum of squared deviations
                sq_sum = '0;
                foreach (matrix_entries[k]) begin
                    trial = 128'(matrix_entries[k]) << FRAC_W;
                    dev   = (trial >= mean_fx) ? trial - mean_fx : mean_fx - trial;
                    acc   = {1'b0, sq_sum} + {1'b0, dev * dev};
                    if (acc[128]) begin
                        sq_sum = '1;
                        sat    = 1'b1;
                    end else begin
                        sq_sum = acc[127:0];
                    end
                end
                var_fx = sq_sum / 128'(n);
                // Bitwise integer square root, 64-bit result
                root = '0;
                for (int b = 63; b >= 0; b--) begin
                    trial = root | (128'(1) << b);
                    if (trial * trial <= var_fx)
                        root = trial;
                end
                quo = ((root * PCT_SCALE) << FRAC_W) / mean_fx;
                if (quo > 128'(RESULT_MAX)) begin
                    cv.variation_percent = RESULT_MAX;
                    sat = 1'b1;
                end else begin
                    cv.variation_percent = quo[RESULT_W-1:0];
                end
            end
            cv.overflow_seen = matrix_dropped | sat;
            expected_cv.push_back(cv);
            matrix_entries.delete();
            matrix_sum     = '0;
            matrix_dropped = 1'b0;
        end
    endtask

    // Send one entry beat; idles between bursts unless the sender is steady
    task automatic send_entry(input logic [ENTRY_W-1:0] value, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                entry_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        entry_if.valid <= 1'b1;
        entry_if.data  <= '{entry_value: value, last_entry: last};
        do @(posedge i_clk); while (!entry_if.ready);
        items_sent++;
        fold_entry(value, last);
    endtask

    // Hold the sender off until every predicted result has arrived
    task automatic wait_results_drained();
        entry_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_cv.size() != 0);
    endtask

    task automatic send_matrix(input matrix_mix_e mix, input int unsigned size);
        logic [ENTRY_W-1:0] level, value;
        level = ENTRY_W'($urandom());
        for (int unsigned k = 0; k < size; k++) begin
            case (mix)
                MIX_FULL_RANGE: value = ENTRY_W'($urandom());
                MIX_SMALL:      value = ENTRY_W'($urandom_range(0, 3));
                MIX_CONSTANT:   value = level;
                MIX_ZERO:       value = '0;
                default: begin
                    case ($urandom_range(0, 2))
                        0:       value = '0;
                        1:       value = ENTRY_MAX;
                        default: value = ENTRY_W'($urandom());
                    endcase
                end
            endcase
            send_entry(value, k == size - 1);
        end
    endtask

    // Single entries, zero mean, opposite extremes, alternating bit patterns
    task automatic test_field_extremes();
        send_entry(ENTRY_MAX, 1'b1);
        send_entry('0, 1'b1);
        send_entry('0, 1'b0);
        send_entry(ENTRY_MAX, 1'b1);
        repeat (2) send_entry(ENTRY_MAX, 1'b0);
        send_entry(ENTRY_MAX, 1'b1);
        repeat (2) send_entry('0, 1'b0);
        send_entry('0, 1'b1);
        send_entry(20'd1, 1'b0);
        repeat (2) send_entry('0, 1'b0);
        send_entry('0, 1'b1);
        send_entry(20'h55555, 1'b0);
        send_entry(20'hAAAAA, 1'b1);
        for (int v = 1; v <= 5; v++)
            send_entry(ENTRY_W'(v), v == 5);
        wait_results_drained();
    endtask

    // Lone unit entry among zeros at the size where the truncated mean hurts
    // most: the largest ratio the store can produce
    task automatic test_widest_spread();
        sender_steady = 1'b1;
        send_entry(20'd1, 1'b0);
        repeat (3854) send_entry('0, 1'b0);
        send_entry('0, 1'b1);
        sender_steady = 1'b0;
        wait_results_drained();
    endtask

    // Exactly full store, then overflowing ones (zero mean and random values)
    task automatic test_store_limits();
        send_matrix(MIX_FULL_RANGE, STORE_DEPTH);
        send_matrix(MIX_ZERO, STORE_DEPTH + 3);
        send_matrix(MIX_EXTREMES, STORE_DEPTH + 4);
        wait_results_drained();
    endtask

    // Long output hold: block finishes a matrix, holds it, then stalls input
    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        for (int m = 0; m < 6; m++)
            send_matrix(MIX_FULL_RANGE, $urandom_range(2, 6));
        wait_results_drained();
    endtask

    task automatic test_random_matrices();
        int unsigned start_items, size, pick;
        matrix_mix_e mix;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      mix = MIX_FULL_RANGE;
            else if (pick < 65) mix = MIX_SMALL;
            else if (pick < 75) mix = MIX_CONSTANT;
            else if (pick < 85) mix = MIX_ZERO;
            else                mix = MIX_EXTREMES;
            pick = $urandom_range(0, 99);
            if (pick < 80)      size = $urandom_range(1, 12);
            else if (pick < 98) size = $urandom_range(13, 100);
            else                size = $urandom_range(101, 400);
            if ($urandom_range(0, 7) == 0)
                sender_steady = !sender_steady;
            send_matrix(mix, size);
        end
        sender_steady = 1'b0;
        wait_results_drained();
    endtask

    // Result sink: pacing changes on its own timer; long hold on request
    initial begin : cv_sink
        int unsigned  pacing_left, phase, period, hold_left;
        sink_pacing_e pacing;
        logic         take;
        cv_if.ready <= 1'b0;
        pacing_left = 0;
        phase       = 0;
        period      = 2;
        hold_left   = 0;
        pacing      = SINK_OPEN;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (pacing_left == 0) begin
                pacing      = sink_pacing_e'($urandom_range(0, 2));
                pacing_left = $urandom_range(40, 400);
                period      = $urandom_range(2, 8);
            end
            pacing_left--;
            phase++;
            if (hold_left != 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                case (pacing)
                    SINK_OPEN:   take = 1'b1;
                    SINK_RANDOM: take = 1'($urandom_range(0, 1));
                    default:     take = (phase % period) == 0;
                endcase
            end
            cv_if.ready <= take;
        end
    end

    // Result checker: each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat got, want;
        if (i_rst_n && cv_if.valid && cv_if.ready) begin
            got = cv_if.data;
            if (expected_cv.size() == 0) begin
                $error("unexpected result beat: variation_percent %0d", got.variation_percent);
                mismatch_count++;
            end else begin
                want = expected_cv.pop_front();
                if (got.variation_percent !== want.variation_percent) begin
                    $error("variation_percent: expected %0d, got %0d",
                           want.variation_percent, got.variation_percent);
                    mismatch_count++;
                end
                if (got.mean_zero !== want.mean_zero) begin
                    $error("mean_zero: expected %0b, got %0b", want.mean_zero, got.mean_zero);
                    mismatch_count++;
                end
                if (got.overflow_seen !== want.overflow_seen) begin
                    $error("overflow_seen: expected %0b, got %0b",
                           want.overflow_seen, got.overflow_seen);
                    mismatch_count++;
                end
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n        <= 1'b0;
        entry_if.valid <= 1'b0;
        entry_if.data  <= '0;
        matrix_sum     = '0;
        matrix_dropped = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        burst_left     = 0;
        sender_steady  = 1'b0;
        long_hold_req  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_widest_spread();
        test_store_limits();
        test_output_backpressure();
        test_random_matrices();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_cv.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
